[rtl/core/mclc_pkg.sv]
// ----------------------------------------------------------------------------
// mclc_pkg
// Shared codes and field widths of the MESI coherent LRU cache block.
// ----------------------------------------------------------------------------
package mclc_pkg;

    localparam int CORE_W  = 3;
    localparam int MASK_W  = 8;
    localparam int COUNT_W = 7;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_STORE = 2'd1;
    localparam logic [1:0] OP_FLUSH = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    localparam logic [1:0] MESI_I = 2'd0;
    localparam logic [1:0] MESI_S = 2'd1;
    localparam logic [1:0] MESI_E = 2'd2;
    localparam logic [1:0] MESI_M = 2'd3;

    localparam logic [1:0] OUT_HIT      = 2'd0;
    localparam logic [1:0] OUT_MISS_ABS = 2'd1;
    localparam logic [1:0] OUT_MISS_INV = 2'd2;

    localparam logic [1:0] EV_NONE     = 2'd0;
    localparam logic [1:0] EV_RD_MISS  = 2'd1;
    localparam logic [1:0] EV_WR_MISS  = 2'd2;
    localparam logic [1:0] EV_WR_HIT   = 2'd3;

    localparam logic [1:0] CFG_ACTIVE_CORES    = 2'd0;
    localparam logic [1:0] CFG_LINES_PER_CACHE = 2'd1;
    localparam logic [1:0] CFG_BLOCK_SHIFT     = 2'd2;

endpackage

[rtl/core/mclc_ram.sv]
// ----------------------------------------------------------------------------
// mclc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mclc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/mesi_coherent_lru_caches_top.sv]
// ----------------------------------------------------------------------------
// mesi_coherent_lru_caches_top
// Fully associative LRU caches for up to eight cores, kept coherent by MESI
// snooping, with a per-core count of modified lines on flush.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake                  | word
//  ----------+-----------+----------------------------+------------------------
//  request   | in        | i_valid / o_stall          | operation, core, address
//  result    | out       | o_valid / i_stall          | core_id .. last
//  config    | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
//  Access: one scan pass plus one update pass over the line RAMs,
//  one row per cycle through each core's RAM port.
//  Flush: one scan pass, then one word per active core.
//  After reset a clearing pass over all rows empties all caches.
//  Stall on the result side holds the output register and the sequencer.
// ----------------------------------------------------------------------------
module mesi_coherent_lru_caches_top #(
    parameter int MAX_CORES = 8,
    parameter int MAX_LINES = 64,
    parameter int ADDR_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [1:0]           i_operation,
    input  logic [2:0]           i_core,
    input  logic [ADDR_BITS-1:0] i_address,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [2:0]           o_core_id,
    output logic [1:0]           o_outcome,
    output logic                 o_evicted,
    output logic                 o_evict_writeback,
    output logic [1:0]           o_bus_event,
    output logic [7:0]           o_snoop_writeback_mask,
    output logic [1:0]           o_line_state,
    output logic [6:0]           o_modified_count,
    output logic                 o_last,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [6:0]           i_cfg_data
);
    import mclc_pkg::*;

    localparam int LW      = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int CW      = $clog2(MAX_LINES + 1);
    localparam int CIW     = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
    localparam int DW      = ADDR_BITS + LW + 3;
    localparam int RANK_LO = ADDR_BITS;
    localparam int MESI_LO = ADDR_BITS + LW;
    localparam logic [LW-1:0] LAST_IDX = LW'(MAX_LINES - 1);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_UPD    = 3'd4;
    localparam logic [2:0] S_AOUT   = 3'd5;
    localparam logic [2:0] S_FOUT   = 3'd6;

    logic [2:0]           r_state;
    logic [3:0]           r_active_cores;
    logic [6:0]           r_lines_per_cache;
    logic [3:0]           r_block_shift;
    logic [LW:0]          r_ridx;
    logic                 r_pv;
    logic [LW-1:0]        r_pidx;
    logic [1:0]           r_op;
    logic [2:0]           r_core;
    logic [ADDR_BITS-1:0] r_tag;
    logic [CW-1:0]        r_held [MAX_CORES];
    logic [CW-1:0]        r_cnt [MAX_CORES];
    logic [2:0]           r_oi;

    logic                 r_hit_f;
    logic [LW-1:0]        r_hit_idx;
    logic [LW-1:0]        r_hit_rank;
    logic [1:0]           r_hit_mesi;
    logic                 r_free_f;
    logic [LW-1:0]        r_free_idx;
    logic                 r_lru_f;
    logic [LW-1:0]        r_lru_idx;
    logic [LW-1:0]        r_lru_rank;
    logic [1:0]           r_lru_mesi;
    logic                 r_m_f [MAX_CORES];
    logic [LW-1:0]        r_m_idx [MAX_CORES];
    logic [LW-1:0]        r_m_rank [MAX_CORES];
    logic [1:0]           r_m_mesi [MAX_CORES];

    logic [LW-1:0]        r_s;
    logic                 r_miss;
    logic [1:0]           r_new_mesi;

    logic                 r_ovld;
    logic [2:0]           r_o_core;
    logic [1:0]           r_o_outcome;
    logic                 r_o_evicted;
    logic                 r_o_ewb;
    logic [1:0]           r_o_ev;
    logic [7:0]           r_o_mask;
    logic [1:0]           r_o_state;
    logic [6:0]           r_o_count;
    logic                 r_o_last;

    logic [1:0]           r_d_outcome;
    logic                 r_d_evicted;
    logic                 r_d_ewb;
    logic [1:0]           r_d_ev;
    logic [7:0]           r_d_mask;

    logic [2:0]           n_state;
    logic [3:0]           nc;
    logic [CIW-1:0]       req;
    logic [DW-1:0]        w_rdata [MAX_CORES];
    logic                 w_we [MAX_CORES];
    logic [LW-1:0]        w_waddr [MAX_CORES];
    logic [DW-1:0]        w_wdata [MAX_CORES];
    logic                 w_occ [MAX_CORES];
    logic [1:0]           w_mesi [MAX_CORES];
    logic [LW-1:0]        w_rank [MAX_CORES];
    logic [ADDR_BITS-1:0] w_tag [MAX_CORES];

    logic [LW-1:0]        d_s;
    logic [1:0]           d_outcome;
    logic                 d_evicted;
    logic                 d_ewb;
    logic [1:0]           d_ev;
    logic [1:0]           d_new_mesi;
    logic [7:0]           d_mask;
    logic [CW-1:0]        d_held;
    logic                 d_ov;
    logic [1:0]           d_snp_mesi [MAX_CORES];
    logic [31:0]          cap32;
    logic [31:0]          held32;
    logic [31:0]          fcnt32;

    assign nc  = (r_active_cores == 4'd0) ? 4'd1 :
                 ((32'(r_active_cores) > MAX_CORES) ? 4'(MAX_CORES) : r_active_cores);
    assign req = r_core[CIW-1:0];

    for (genvar g = 0; g < MAX_CORES; g++) begin : g_core
        mclc_ram #(
            .WIDTH (DW),
            .DEPTH (MAX_LINES)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (w_we[g]),
            .i_waddr (w_waddr[g]),
            .i_wdata (w_wdata[g]),
            .i_raddr (r_ridx[LW-1:0]),
            .o_rdata (w_rdata[g])
        );
        assign w_occ[g]  = w_rdata[g][DW-1];
        assign w_mesi[g] = w_rdata[g][MESI_LO +: 2];
        assign w_rank[g] = w_rdata[g][RANK_LO +: LW];
        assign w_tag[g]  = w_rdata[g][ADDR_BITS-1:0];
    end

    always_comb begin
        cap32 = (r_lines_per_cache == 7'd0) ? 32'd1 :
                ((32'(r_lines_per_cache) > MAX_LINES) ? 32'(MAX_LINES)
                                                      : 32'(r_lines_per_cache));
        held32     = 32'(r_held[req]);
        d_s        = r_hit_idx;
        d_outcome  = OUT_HIT;
        d_evicted  = 1'b0;
        d_ewb      = 1'b0;
        d_held     = r_held[req];
        d_ev       = EV_NONE;
        d_new_mesi = r_hit_mesi;
        d_mask     = '0;
        d_ov       = 1'b0;
        if (r_hit_f) begin
            d_outcome = (r_hit_mesi == MESI_I) ? OUT_MISS_INV : OUT_HIT;
        end else begin
            d_outcome = OUT_MISS_ABS;
            if (held32 < cap32 && r_free_f) begin
                d_s    = r_free_idx;
                d_held = CW'(held32 + 32'd1);
            end else if (r_lru_f) begin
                d_s       = r_lru_idx;
                d_evicted = 1'b1;
                d_ewb     = (r_lru_mesi == MESI_M);
            end else begin
                d_s    = '0;
                d_held = CW'(1);
            end
        end
        for (int k = 0; k < MAX_CORES; k++) begin
            if (r_m_f[k] && r_m_mesi[k] != MESI_I) begin
                d_ov = 1'b1;
            end
        end
        if (r_op == OP_LOAD) begin
            if (d_outcome != OUT_HIT) begin
                d_new_mesi = d_ov ? MESI_S : MESI_E;
                d_ev       = EV_RD_MISS;
            end
        end else begin
            if (d_outcome != OUT_HIT) begin
                d_ev = EV_WR_MISS;
            end else if (r_hit_mesi == MESI_S) begin
                d_ev = EV_WR_HIT;
            end
            d_new_mesi = MESI_M;
        end
        for (int k = 0; k < MAX_CORES; k++) begin
            d_snp_mesi[k] = r_m_mesi[k];
            if (r_m_f[k]) begin
                unique case (d_ev)
                    EV_RD_MISS: begin
                        if (r_m_mesi[k] == MESI_M) begin
                            d_mask[k]     = 1'b1;
                            d_snp_mesi[k] = MESI_S;
                        end else if (r_m_mesi[k] == MESI_E) begin
                            d_snp_mesi[k] = MESI_S;
                        end
                    end
                    EV_WR_MISS: begin
                        if (r_m_mesi[k] == MESI_M) begin
                            d_mask[k] = 1'b1;
                        end
                        d_snp_mesi[k] = MESI_I;
                    end
                    EV_WR_HIT: begin
                        if (r_m_mesi[k] == MESI_S) begin
                            d_snp_mesi[k] = MESI_I;
                        end
                    end
                    default: begin
                        d_snp_mesi[k] = r_m_mesi[k];
                    end
                endcase
            end
        end
    end

    always_comb begin
        for (int k = 0; k < MAX_CORES; k++) begin
            w_we[k]    = 1'b0;
            w_waddr[k] = r_pidx;
            w_wdata[k] = '0;
            if (r_state == S_CLEAR) begin
                w_we[k]    = 1'b1;
                w_waddr[k] = r_ridx[LW-1:0];
            end else if (r_state == S_DECIDE) begin
                if (3'(k) != r_core && r_m_f[k] && d_ev != EV_NONE) begin
                    w_we[k]    = 1'b1;
                    w_waddr[k] = r_m_idx[k];
                    w_wdata[k] = {1'b1, d_snp_mesi[k], r_m_rank[k], r_tag};
                end
            end else if (r_state == S_UPD && 3'(k) == r_core && r_pv) begin
                if (r_pidx == r_s) begin
                    w_we[k]    = 1'b1;
                    w_wdata[k] = {1'b1, r_new_mesi, {LW{1'b0}}, r_tag};
                end else if (w_occ[k]) begin
                    w_we[k]    = 1'b1;
                    w_wdata[k] = {1'b1, w_mesi[k],
                                  (r_miss || w_rank[k] < r_hit_rank)
                                      ? LW'(w_rank[k] + 1'b1) : w_rank[k],
                                  w_tag[k]};
                end
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_ridx[LW-1:0] == LAST_IDX) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    if (i_operation == OP_FLUSH) begin
                        n_state = S_SCAN;
                    end else if (i_operation != OP_NONE && {1'b0, i_core} < nc) begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_pv && r_pidx == LAST_IDX) begin
                    n_state = (r_op == OP_FLUSH) ? S_FOUT : S_DECIDE;
                end
            end
            S_DECIDE: n_state = S_UPD;
            S_UPD: begin
                if (r_pv && r_pidx == LAST_IDX) begin
                    n_state = S_AOUT;
                end
            end
            S_AOUT: begin
                if (!r_ovld || !i_stall) begin
                    n_state = S_IDLE;
                end
            end
            S_FOUT: begin
                if ((!r_ovld || !i_stall) && {1'b0, r_oi} == nc - 4'd1) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign fcnt32 = 32'(r_cnt[r_oi[CIW-1:0]]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= S_CLEAR;
            r_active_cores    <= 4'd2;
            r_lines_per_cache <= 7'd64;
            r_block_shift     <= 4'd5;
            r_ridx            <= '0;
            r_pv              <= 1'b0;
            r_ovld            <= 1'b0;
            for (int k = 0; k < MAX_CORES; k++) begin
                r_held[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_ACTIVE_CORES:    r_active_cores    <= i_cfg_data[3:0];
                    CFG_LINES_PER_CACHE: r_lines_per_cache <= i_cfg_data;
                    CFG_BLOCK_SHIFT:     r_block_shift     <= i_cfg_data[3:0];
                    default:             r_block_shift     <= r_block_shift;
                endcase
            end
            if (r_ovld && !i_stall && r_state != S_AOUT && r_state != S_FOUT) begin
                r_ovld <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_ridx <= (r_ridx[LW-1:0] == LAST_IDX) ? '0 : r_ridx + 1'b1;
                end
                S_IDLE: begin
                    r_op     <= i_operation;
                    r_core   <= i_core;
                    r_tag    <= i_address >> r_block_shift;
                    r_ridx   <= '0;
                    r_pv     <= 1'b0;
                    r_oi     <= '0;
                    r_hit_f  <= 1'b0;
                    r_free_f <= 1'b0;
                    r_lru_f  <= 1'b0;
                    for (int k = 0; k < MAX_CORES; k++) begin
                        r_m_f[k] <= 1'b0;
                        r_cnt[k] <= '0;
                    end
                end
                S_SCAN, S_UPD: begin
                    if (r_pv && r_pidx == LAST_IDX) begin
                        r_ridx <= '0;
                        r_pv   <= 1'b0;
                    end else if (r_ridx < (LW+1)'(MAX_LINES)) begin
                        r_ridx <= r_ridx + 1'b1;
                        r_pv   <= 1'b1;
                        r_pidx <= r_ridx[LW-1:0];
                    end else begin
                        r_pv <= 1'b0;
                    end
                    if (r_state == S_SCAN && r_pv) begin
                        for (int k = 0; k < MAX_CORES; k++) begin
                            if (r_op == OP_FLUSH) begin
                                if (w_occ[k] && w_mesi[k] == MESI_M) begin
                                    r_cnt[k] <= r_cnt[k] + 1'b1;
                                end
                            end else if (3'(k) == r_core) begin
                                if (!r_hit_f && w_occ[k] && w_tag[k] == r_tag) begin
                                    r_hit_f    <= 1'b1;
                                    r_hit_idx  <= r_pidx;
                                    r_hit_rank <= w_rank[k];
                                    r_hit_mesi <= w_mesi[k];
                                end
                                if (!r_free_f && !w_occ[k]) begin
                                    r_free_f   <= 1'b1;
                                    r_free_idx <= r_pidx;
                                end
                                if (w_occ[k] && (!r_lru_f || w_rank[k] > r_lru_rank)) begin
                                    r_lru_f    <= 1'b1;
                                    r_lru_idx  <= r_pidx;
                                    r_lru_rank <= w_rank[k];
                                    r_lru_mesi <= w_mesi[k];
                                end
                            end else if (4'(k) < nc && !r_m_f[k] && w_occ[k]
                                         && w_tag[k] == r_tag) begin
                                r_m_f[k]    <= 1'b1;
                                r_m_idx[k]  <= r_pidx;
                                r_m_rank[k] <= w_rank[k];
                                r_m_mesi[k] <= w_mesi[k];
                            end
                        end
                    end
                end
                S_DECIDE: begin
                    r_s         <= d_s;
                    r_miss      <= !r_hit_f;
                    r_new_mesi  <= d_new_mesi;
                    r_d_outcome <= d_outcome;
                    r_d_evicted <= d_evicted;
                    r_d_ewb     <= d_ewb;
                    r_d_ev      <= d_ev;
                    r_d_mask    <= d_mask;
                    r_held[req] <= d_held;
                end
                S_AOUT: begin
                    if (!r_ovld || !i_stall) begin
                        r_ovld      <= 1'b1;
                        r_o_core    <= r_core;
                        r_o_outcome <= r_d_outcome;
                        r_o_evicted <= r_d_evicted;
                        r_o_ewb     <= r_d_ewb;
                        r_o_ev      <= r_d_ev;
                        r_o_mask    <= r_d_mask;
                        r_o_state   <= r_new_mesi;
                        r_o_count   <= '0;
                        r_o_last    <= 1'b1;
                    end
                end
                S_FOUT: begin
                    if (!r_ovld || !i_stall) begin
                        r_ovld      <= 1'b1;
                        r_o_core    <= r_oi;
                        r_o_outcome <= OUT_HIT;
                        r_o_evicted <= 1'b0;
                        r_o_ewb     <= 1'b0;
                        r_o_ev      <= EV_NONE;
                        r_o_mask    <= '0;
                        r_o_state   <= MESI_I;
                        r_o_count   <= (fcnt32 > 32'd127) ? 7'd127 : fcnt32[6:0];
                        r_o_last    <= ({1'b0, r_oi} == nc - 4'd1);
                        r_oi        <= r_oi + 1'b1;
                    end
                end
                default: r_pv <= 1'b0;
            endcase
        end
    end

    assign o_stall                = (r_state != S_IDLE);
    assign o_cfg_ready            = 1'b1;
    assign o_valid                = r_ovld;
    assign o_core_id              = r_o_core;
    assign o_outcome              = r_o_outcome;
    assign o_evicted              = r_o_evicted;
    assign o_evict_writeback      = r_o_ewb;
    assign o_bus_event            = r_o_ev;
    assign o_snoop_writeback_mask = r_o_mask;
    assign o_line_state           = r_o_state;
    assign o_modified_count       = r_o_count;
    assign o_last                 = r_o_last;

    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_UPD |-> 32'(r_held[req]) <= MAX_LINES)
        else $error("lines held exceeds cache capacity");

    a_no_self_snoop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_snoop_writeback_mask[o_core_id])
        else $error("requester reported in its own snoop write-back mask");

    a_wb_needs_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_evict_writeback |-> o_evicted && o_outcome == OUT_MISS_ABS)
        else $error("write-back without replacement");

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the MESI coherent LRU cache block: a directed table
// of loads, stores and flush reports, then random traffic, every result word
// compared in order against a behavioral copy of the caches kept here.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mclc_pkg::*;

    localparam int NC = 8;
    localparam int NL = 64;
    localparam int LIMIT = 2000000;

    typedef struct packed {
        logic [2:0] core_id;
        logic [1:0] outcome;
        logic       evicted;
        logic       evict_writeback;
        logic [1:0] bus_event;
        logic [7:0] snoop_writeback_mask;
        logic [1:0] line_state;
        logic [6:0] modified_count;
        logic       last;
    } t_result;

    typedef struct {
        logic [1:0]  op;
        logic [2:0]  core;
        logic [31:0] addr;
        logic        fixed;
        t_result     res;
    } t_row;

    logic        i_clk = 0, i_rst_n = 0;
    logic        i_valid = 0, i_stall = 0;
    logic [1:0]  i_operation = 0;
    logic [2:0]  i_core = 0;
    logic [31:0] i_address = 0;
    logic        i_cfg_valid = 0;
    logic [1:0]  i_cfg_index = 0;
    logic [6:0]  i_cfg_data = 0;
    logic        o_stall, o_valid, o_cfg_ready;
    logic [2:0]  o_core_id;
    logic [1:0]  o_outcome, o_bus_event, o_line_state;
    logic        o_evicted, o_evict_writeback, o_last;
    logic [7:0]  o_snoop_writeback_mask;
    logic [6:0]  o_modified_count;

    mesi_coherent_lru_caches_top dut (.*);

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    // behavioral copy of the caches
    logic        occ [NC][NL];
    logic [31:0] tagv [NC][NL];
    logic [1:0]  mesi [NC][NL];
    int          rank [NC][NL];
    int          held [NC];
    logic [3:0]  cfg_cores;
    logic [6:0]  cfg_lines;
    logic [3:0]  cfg_shift;

    t_result expected_words[$];
    int      errors = 0;
    int      cycles = 0;
    int      stall_mode = 0;
    bit      hold_off = 0;
    bit      quiet = 0;

    function automatic int find_line(int c, logic [31:0] t);
        for (int j = 0; j < NL; j++)
            if (occ[c][j] && tagv[c][j] == t) return j;
        return -1;
    endfunction

    function automatic int active_count();
        if (cfg_cores < 1) return 1;
        if (cfg_cores > NC) return NC;
        return cfg_cores;
    endfunction

    task automatic predict_access(logic [1:0] op, logic [2:0] core, logic [31:0] addr);
        int nc, s, cap, best, c, r, j;
        logic [31:0] t;
        t_result w;
        bit othv;
        nc = active_count();
        c = core;
        w = '0;
        if (op == OP_NONE) return;
        if (op == OP_FLUSH) begin
            for (int i = 0; i < nc; i++) begin
                w = '0;
                w.core_id = 3'(i);
                for (j = 0; j < NL; j++)
                    if (occ[i][j] && mesi[i][j] == MESI_M) w.modified_count++;
                w.last = (i == nc - 1);
                expected_words.push_back(w);
            end
            return;
        end
        if (c >= nc) return;
        t = addr >> cfg_shift;
        s = find_line(c, t);
        if (s < 0) begin
            cap = (cfg_lines < 1) ? 1 : (cfg_lines > NL ? NL : cfg_lines);
            w.outcome = OUT_MISS_ABS;
            if (held[c] < cap) begin
                for (j = 0; j < NL && s < 0; j++)
                    if (!occ[c][j]) s = j;
                if (s >= 0) held[c]++;
            end
            if (s < 0) begin
                best = -1;
                for (j = 0; j < NL; j++)
                    if (occ[c][j] && (best < 0 || rank[c][j] > rank[c][best])) best = j;
                if (best < 0) begin
                    best = 0;
                    held[c] = 1;
                end
                s = best;
                w.evicted = occ[c][s];
                w.evict_writeback = occ[c][s] && mesi[c][s] == MESI_M;
            end
            for (j = 0; j < NL; j++)
                if (j != s && occ[c][j]) rank[c][j]++;
            occ[c][s] = 1;
            tagv[c][s] = t;
            rank[c][s] = 0;
        end else begin
            w.outcome = (mesi[c][s] == MESI_I) ? OUT_MISS_INV : OUT_HIT;
            r = rank[c][s];
            for (j = 0; j < NL; j++)
                if (j != s && occ[c][j] && rank[c][j] < r) rank[c][j]++;
            rank[c][s] = 0;
        end
        if (op == OP_LOAD) begin
            if (w.outcome != OUT_HIT) begin
                othv = 0;
                for (int k = 0; k < nc; k++) begin
                    j = (k == c) ? -1 : find_line(k, t);
                    if (j >= 0 && mesi[k][j] != MESI_I) othv = 1;
                end
                mesi[c][s] = othv ? MESI_S : MESI_E;
                w.bus_event = EV_RD_MISS;
            end
        end else begin
            if (w.outcome != OUT_HIT) w.bus_event = EV_WR_MISS;
            else if (mesi[c][s] == MESI_S) w.bus_event = EV_WR_HIT;
            mesi[c][s] = MESI_M;
        end
        if (w.bus_event != EV_NONE) begin
            for (int k = 0; k < nc; k++) begin
                j = (k == c) ? -1 : find_line(k, t);
                if (j < 0) continue;
                case (w.bus_event)
                    EV_RD_MISS: begin
                        if (mesi[k][j] == MESI_M) begin
                            w.snoop_writeback_mask[k] = 1;
                            mesi[k][j] = MESI_S;
                        end else if (mesi[k][j] == MESI_E) begin
                            mesi[k][j] = MESI_S;
                        end
                    end
                    EV_WR_MISS: begin
                        if (mesi[k][j] == MESI_M) w.snoop_writeback_mask[k] = 1;
                        mesi[k][j] = MESI_I;
                    end
                    default: begin
                        if (mesi[k][j] == MESI_S) mesi[k][j] = MESI_I;
                    end
                endcase
            end
        end
        w.core_id = core;
        w.line_state = mesi[c][s];
        w.last = 1;
        expected_words.push_back(w);
    endtask

    task automatic send_word(logic [1:0] op, logic [2:0] core, logic [31:0] addr);
        while (!quiet && $urandom_range(99) < 16) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid     <= 1;
        i_operation <= op;
        i_core      <= core;
        i_address   <= addr;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_access(op, core, addr);
    endtask

    task automatic drain();
        i_valid <= 0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (2 * NL + 20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [6:0] val);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 0;
        case (idx)
            CFG_ACTIVE_CORES:    cfg_cores = val[3:0];
            CFG_LINES_PER_CACHE: cfg_lines = val;
            default:             cfg_shift = val[3:0];
        endcase
        @(posedge i_clk);
    endtask

    task automatic setup(logic [6:0] nc, logic [6:0] nl, logic [6:0] sh);
        drain();
        write_reg(CFG_ACTIVE_CORES, nc);
        write_reg(CFG_LINES_PER_CACHE, nl);
        write_reg(CFG_BLOCK_SHIFT, sh);
    endtask

    // result side: random stall, a quiet stretch, and one long hold-off
    always @(posedge i_clk) begin
        if (hold_off) i_stall <= 1;
        else if (stall_mode == 1) i_stall <= 0;
        else i_stall <= ($urandom_range(99) < 16);
    end

    always @(posedge i_clk) begin
        t_result got, want;
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("FAIL");
            $finish;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_core_id, o_outcome, o_evicted, o_evict_writeback, o_bus_event,
                    o_snoop_writeback_mask, o_line_state, o_modified_count, o_last};
            if (expected_words.size() == 0) begin
                $display("%0t unexpected word, expected none, actual %h", $time, got);
                errors++;
            end else begin
                want = expected_words.pop_front();
                if (got !== want) begin
                    $display("%0t mismatch expected %p actual %p", $time, want, got);
                    errors++;
                end
            end
        end
    end

    function automatic logic [31:0] rand_addr(int pool);
        logic [31:0] a;
        a = $urandom();
        if ($urandom_range(9) < 8)
            a = ($urandom_range(pool - 1) << cfg_shift) | (a & ((32'd1 << cfg_shift) - 1));
        return a;
    endfunction

    t_row    tbl[$];
    t_result fx;

    initial begin
        int nc, pool;
        logic [1:0] op;
        cfg_cores = 2;
        cfg_lines = 64;
        cfg_shift = 5;
        foreach (occ[c, j]) begin
            occ[c][j] = 0;
            tagv[c][j] = 0;
            mesi[c][j] = 0;
            rank[c][j] = 0;
        end
        foreach (held[c]) held[c] = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        repeat (NL + 4) @(posedge i_clk);

        // after reset: flush of empty caches, then a cold load
        fx = '0; fx.core_id = 0;
        tbl.push_back('{OP_FLUSH, 3'd5, 32'h0, 0, fx});
        fx.core_id = 1; fx.last = 1;
        tbl.push_back('{OP_FLUSH, 3'd0, 32'h0, 1, fx});
        fx = '0; fx.core_id = 0; fx.outcome = OUT_MISS_ABS; fx.bus_event = EV_RD_MISS;
        fx.line_state = MESI_E; fx.last = 1;
        tbl.push_back('{OP_LOAD, 3'd0, 32'hFFFF_FFFF, 1, fx});
        fx = '0;
        tbl.push_back('{OP_LOAD, 3'd1, 32'hFFFF_FFE0, 0, fx});
        tbl.push_back('{OP_STORE, 3'd1, 32'hFFFF_FFE1, 0, fx});
        tbl.push_back('{OP_LOAD, 3'd0, 32'hFFFF_FFFF, 0, fx});
        tbl.push_back('{OP_STORE, 3'd0, 32'hFFFF_FFFF, 0, fx});
        tbl.push_back('{OP_LOAD, 3'd1, 32'hFFFF_FFE0, 0, fx});
        tbl.push_back('{OP_STORE, 3'd0, 32'h0000_0000, 0, fx});
        tbl.push_back('{OP_STORE, 3'd0, 32'h0000_0010, 0, fx});
        tbl.push_back('{OP_NONE, 3'd0, 32'h0, 0, fx});
        tbl.push_back('{OP_LOAD, 3'd7, 32'h0, 0, fx});
        tbl.push_back('{OP_FLUSH, 3'd0, 32'h0, 0, fx});
        foreach (tbl[i]) begin
            send_word(tbl[i].op, tbl[i].core, tbl[i].addr);
            if (tbl[i].fixed && expected_words.size() != 0) begin
                if (expected_words[$] !== tbl[i].res) begin
                    $display("%0t table row %0d expected %p actual %p", $time, i,
                             tbl[i].res, expected_words[$]);
                    errors++;
                end
            end
        end

        // all cores, single-line caches, extreme shifts
        setup(7'd8, 7'd1, 7'd0);
        for (int i = 0; i < 8; i++) send_word(i[0] ? OP_STORE : OP_LOAD, 3'(i), 32'h80);
        send_word(OP_LOAD, 3'd3, 32'h81);
        send_word(OP_STORE, 3'd3, 32'h80);
        send_word(OP_FLUSH, 3'd0, 32'h0);
        setup(7'd0, 7'd0, 7'd12);
        send_word(OP_LOAD, 3'd0, 32'hFFFF_F000);
        send_word(OP_LOAD, 3'd1, 32'h0);
        setup(7'd15, 7'd127, 7'd15);
        send_word(OP_STORE, 3'd7, 32'hFFFF_FFFF);
        send_word(OP_FLUSH, 3'd0, 32'h0);

        // random phases across settings
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: setup(7'd4, 7'd4, 7'd2);
                1: setup(7'd8, 7'd64, 7'd5);
                2: setup(7'd1, 7'd2, 7'd0);
                3: setup(7'd3, 7'd8, 7'd12);
                4: setup(7'd8, 7'd3, 7'd7);
                default: setup(7'd2, 7'd16, 7'd4);
            endcase
            stall_mode = (ph == 1);
            quiet = (ph == 1);
            nc = active_count();
            pool = (ph == 1) ? 80 : 12;
            for (int n = 0; n < 48; n++) begin
                if (ph == 3 && n == 10) hold_off = 1;
                if (ph == 3 && n == 30) hold_off = 0;
                if (ph == 4 && n == 24) begin
                    i_valid <= 0;
                    @(posedge i_clk);
                    while (expected_words.size() != 0) @(posedge i_clk);
                end
                case ($urandom_range(19))
                    0: op = OP_FLUSH;
                    1: op = OP_NONE;
                    default: op = 2'($urandom_range(1));
                endcase
                send_word(op, ($urandom_range(9) == 0) ? 3'($urandom())
                                                       : 3'($urandom_range(nc - 1)),
                          rand_addr(pool));
            end
            hold_off = 0;
        end
        stall_mode = 0;
        quiet = 0;
        drain();
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // release a hold-off after a counted stretch even if the sender blocks
    initial begin
        int n;
        n = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                n++;
                if (n >= 600) hold_off = 0;
            end else begin
                n = 0;
            end
        end
    end
endmodule

[sim.f]
rtl/core/mclc_pkg.sv
rtl/core/mclc_ram.sv
rtl/core/mesi_coherent_lru_caches_top.sv
bench/tb.sv
